FILE: rtl/core/ppsf_pkg.sv
// Shared constants, types and the kernel table of the path point smoothing filter.
package ppsf_pkg;

    localparam int COORD_BITS = 32;
    localparam int WIN_LEN    = 7;
    localparam int LAG        = 3;
    localparam int IDX_BITS   = 3;
    localparam int W_BITS     = 8;
    localparam int ACC_BITS   = COORD_BITS + W_BITS;
    localparam int CNT_BITS   = $clog2(ACC_BITS + 1);
    localparam int MODE_BITS  = 2;

    localparam logic [MODE_BITS-1:0] MODE_PASS = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_AVG3 = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_WTD  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_SETUP,
        ST_MAC,
        ST_DIV,
        ST_ROUND,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                shift;
        logic                start;
        logic                mac_en;
        logic                div_start;
        logic                div_step;
        logic                round;
        logic                load_out;
        logic                clear_seen;
        logic [IDX_BITS-1:0] center;
        logic                last;
    } t_cmd;

    typedef struct packed {
        logic [IDX_BITS-1:0] seen;
        logic                mac_done;
        logic                div_done;
        logic                out_free;
    } t_stat;

    // Seven-tap kernel, tap 3 is the centre point.
    function automatic logic [W_BITS-1:0] kernel_weight(input logic [IDX_BITS-1:0] k);
        logic [W_BITS-1:0] w;
        case (k)
            3'd0:    w = 8'd2;
            3'd1:    w = 8'd16;
            3'd2:    w = 8'd38;
            3'd3:    w = 8'd49;
            3'd4:    w = 8'd38;
            3'd5:    w = 8'd16;
            3'd6:    w = 8'd2;
            default: w = 8'd0;
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/core/ppsf_datapath.sv
// Datapath: point window, multiply-accumulate, serial divider and output register.
module ppsf_datapath (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [ppsf_pkg::MODE_BITS-1:0]          i_cfg_data,
    input  logic signed [ppsf_pkg::COORD_BITS-1:0]  i_in_x,
    input  logic signed [ppsf_pkg::COORD_BITS-1:0]  i_in_y,
    input  ppsf_pkg::t_cmd                          i_cmd,
    output ppsf_pkg::t_stat                         o_stat,
    input  logic                                    i_out_ready,
    output logic                                    o_out_valid,
    output logic signed [ppsf_pkg::COORD_BITS-1:0]  o_out_x,
    output logic signed [ppsf_pkg::COORD_BITS-1:0]  o_out_y,
    output logic                                    o_out_last
);
    import ppsf_pkg::*;

    logic [MODE_BITS-1:0]         r_mode;
    logic signed [COORD_BITS-1:0] r_win_x [WIN_LEN];
    logic signed [COORD_BITS-1:0] r_win_y [WIN_LEN];
    logic [IDX_BITS-1:0]          r_seen;

    logic [IDX_BITS-1:0]          r_p;
    logic [IDX_BITS-1:0]          r_hi;
    logic                         r_wtd;
    logic                         r_tap_run;
    logic                         r_prod_vld;
    logic signed [ACC_BITS-1:0]   r_prod_x;
    logic signed [ACC_BITS-1:0]   r_prod_y;
    logic [W_BITS-1:0]            r_prod_w;
    logic signed [ACC_BITS-1:0]   r_acc_x;
    logic signed [ACC_BITS-1:0]   r_acc_y;
    logic [W_BITS-1:0]            r_den;

    logic [CNT_BITS-1:0]          r_div_cnt;
    logic                         r_neg_x;
    logic                         r_neg_y;
    logic [ACC_BITS-1:0]          r_quo_x;
    logic [ACC_BITS-1:0]          r_quo_y;
    logic [W_BITS-1:0]            r_rem_x;
    logic [W_BITS-1:0]            r_rem_y;
    logic [COORD_BITS-1:0]        r_res_x;
    logic [COORD_BITS-1:0]        r_res_y;

    logic                         r_out_vld;
    logic [COORD_BITS-1:0]        r_out_x;
    logic [COORD_BITS-1:0]        r_out_y;
    logic                         r_out_last;

    // Window setup for one emitted point.
    logic [IDX_BITS:0]   w_sum;
    logic [IDX_BITS-1:0] w_nl;
    logic [IDX_BITS-1:0] w_nr_raw;
    logic [IDX_BITS-1:0] w_nr;
    logic [IDX_BITS-1:0] w_lo;
    logic [IDX_BITS-1:0] w_hi;
    logic                w_wtd;

    always_comb begin
        w_sum    = {1'b0, i_cmd.center} + {1'b0, r_seen} - (IDX_BITS + 1)'(WIN_LEN);
        w_nl     = (w_sum > (IDX_BITS + 1)'(LAG)) ? IDX_BITS'(LAG) : w_sum[IDX_BITS-1:0];
        w_nr_raw = IDX_BITS'(WIN_LEN - 1) - i_cmd.center;
        w_nr     = (w_nr_raw > IDX_BITS'(LAG)) ? IDX_BITS'(LAG) : w_nr_raw;
        case (r_mode)
            MODE_WTD: begin
                w_lo  = i_cmd.center - w_nl;
                w_hi  = i_cmd.center + w_nr;
                w_wtd = 1'b1;
            end
            MODE_AVG3: begin
                w_wtd = 1'b0;
                if (w_nl != '0 && w_nr != '0) begin
                    w_lo = i_cmd.center - IDX_BITS'(1);
                    w_hi = i_cmd.center + IDX_BITS'(1);
                end else begin
                    w_lo = i_cmd.center;
                    w_hi = i_cmd.center;
                end
            end
            MODE_PASS: begin
                w_lo  = i_cmd.center;
                w_hi  = i_cmd.center;
                w_wtd = 1'b0;
            end
            default: begin
                w_lo  = i_cmd.center;
                w_hi  = i_cmd.center;
                w_wtd = 1'b0;
            end
        endcase
    end

    // One tap per cycle for both coordinates.
    logic [IDX_BITS-1:0]        w_kidx;
    logic [W_BITS-1:0]          w_w;
    logic signed [ACC_BITS:0]   w_px;
    logic signed [ACC_BITS:0]   w_py;

    always_comb begin
        w_kidx = r_p - i_cmd.center + IDX_BITS'(LAG);
        w_w    = r_wtd ? kernel_weight(w_kidx) : W_BITS'(1);
        w_px   = r_win_x[r_p] * $signed({1'b0, w_w});
        w_py   = r_win_y[r_p] * $signed({1'b0, w_w});
    end

    function automatic logic [W_BITS+ACC_BITS-1:0] div_iter(
        input logic [W_BITS-1:0]   rem,
        input logic [ACC_BITS-1:0] quo,
        input logic [W_BITS-1:0]   den
    );
        logic [W_BITS:0]   trial;
        logic [W_BITS-1:0] nrem;
        logic              qbit;
        trial = {rem, quo[ACC_BITS-1]};
        if (trial >= {1'b0, den}) begin
            nrem = W_BITS'(trial - {1'b0, den});
            qbit = 1'b1;
        end else begin
            nrem = trial[W_BITS-1:0];
            qbit = 1'b0;
        end
        return {nrem, quo[ACC_BITS-2:0], qbit};
    endfunction

    logic [W_BITS+ACC_BITS-1:0] w_step_x;
    logic [W_BITS+ACC_BITS-1:0] w_step_y;
    logic [ACC_BITS-1:0]        w_mag_x;
    logic [ACC_BITS-1:0]        w_mag_y;
    logic                       w_up_x;
    logic                       w_up_y;
    logic [COORD_BITS-1:0]      w_q_x;
    logic [COORD_BITS-1:0]      w_q_y;

    always_comb begin
        w_step_x = div_iter(r_rem_x, r_quo_x, r_den);
        w_step_y = div_iter(r_rem_y, r_quo_y, r_den);
        w_mag_x  = r_acc_x[ACC_BITS-1] ? ACC_BITS'(-r_acc_x) : ACC_BITS'(r_acc_x);
        w_mag_y  = r_acc_y[ACC_BITS-1] ? ACC_BITS'(-r_acc_y) : ACC_BITS'(r_acc_y);
        // Round half away from zero on the magnitude: up when 2*rem >= den.
        w_up_x   = {r_rem_x, 1'b0} >= {1'b0, r_den};
        w_up_y   = {r_rem_y, 1'b0} >= {1'b0, r_den};
        w_q_x    = r_quo_x[COORD_BITS-1:0] + COORD_BITS'(w_up_x);
        w_q_y    = r_quo_y[COORD_BITS-1:0] + COORD_BITS'(w_up_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_PASS;
            r_seen     <= '0;
            r_tap_run  <= 1'b0;
            r_prod_vld <= 1'b0;
            r_div_cnt  <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (i_cmd.clear_seen) begin
                r_seen <= '0;
            end else if (i_cmd.shift && r_seen != IDX_BITS'(WIN_LEN)) begin
                r_seen <= r_seen + IDX_BITS'(1);
            end
            if (i_cmd.start) begin
                r_tap_run  <= 1'b1;
                r_prod_vld <= 1'b0;
            end else if (i_cmd.mac_en) begin
                r_prod_vld <= r_tap_run;
                if (r_tap_run && r_p == r_hi) begin
                    r_tap_run <= 1'b0;
                end
            end
            if (i_cmd.div_start) begin
                r_div_cnt <= CNT_BITS'(ACC_BITS);
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt - CNT_BITS'(1);
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            for (int i = 0; i < WIN_LEN - 1; i++) begin
                r_win_x[i] <= r_win_x[i+1];
                r_win_y[i] <= r_win_y[i+1];
            end
            r_win_x[WIN_LEN-1] <= i_in_x;
            r_win_y[WIN_LEN-1] <= i_in_y;
        end
        if (i_cmd.start) begin
            r_p     <= w_lo;
            r_hi    <= w_hi;
            r_wtd   <= w_wtd;
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_den   <= '0;
        end else if (i_cmd.mac_en) begin
            if (r_tap_run) begin
                r_prod_x <= w_px[ACC_BITS-1:0];
                r_prod_y <= w_py[ACC_BITS-1:0];
                r_prod_w <= w_w;
                r_p      <= r_p + IDX_BITS'(1);
            end
            if (r_prod_vld) begin
                r_acc_x <= r_acc_x + r_prod_x;
                r_acc_y <= r_acc_y + r_prod_y;
                r_den   <= r_den + r_prod_w;
            end
        end
        if (i_cmd.div_start) begin
            r_neg_x <= r_acc_x[ACC_BITS-1];
            r_neg_y <= r_acc_y[ACC_BITS-1];
            r_quo_x <= w_mag_x;
            r_quo_y <= w_mag_y;
            r_rem_x <= '0;
            r_rem_y <= '0;
        end else if (i_cmd.div_step) begin
            {r_rem_x, r_quo_x} <= w_step_x;
            {r_rem_y, r_quo_y} <= w_step_y;
        end
        if (i_cmd.round) begin
            r_res_x <= r_neg_x ? COORD_BITS'(~w_q_x + COORD_BITS'(1)) : w_q_x;
            r_res_y <= r_neg_y ? COORD_BITS'(~w_q_y + COORD_BITS'(1)) : w_q_y;
        end
        if (i_cmd.load_out) begin
            r_out_x    <= r_res_x;
            r_out_y    <= r_res_y;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_stat.seen     = r_seen;
    assign o_stat.mac_done = !r_tap_run && !r_prod_vld;
    assign o_stat.div_done = (r_div_cnt == '0);
    assign o_stat.out_free = !r_out_vld || i_out_ready;

    assign o_out_valid = r_out_vld;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_out_last  = r_out_last;

endmodule

FILE: rtl/core/ppsf_ctrl.sv
// Controller: sequences window update, accumulation, division and result hand-off.
module ppsf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_last,
    input  ppsf_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output ppsf_pkg::t_cmd  o_cmd
);
    import ppsf_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [IDX_BITS-1:0] r_center;
    logic [IDX_BITS-1:0] n_center;
    logic                r_last;
    logic                n_last;
    logic [IDX_BITS-1:0] w_pend;
    logic                w_final;

    assign w_pend  = (i_stat.seen >= IDX_BITS'(LAG + 1)) ? IDX_BITS'(LAG + 1) : i_stat.seen;
    assign w_final = r_last && (r_center == IDX_BITS'(WIN_LEN - 1));

    always_comb begin
        n_state  = r_state;
        n_center = r_center;
        n_last   = r_last;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_PLAN;
                    n_last  = i_in_last;
                end
            end
            ST_PLAN: begin
                if (r_last) begin
                    n_center = IDX_BITS'(WIN_LEN) - w_pend;
                    n_state  = ST_SETUP;
                end else if (i_stat.seen >= IDX_BITS'(LAG + 1)) begin
                    n_center = IDX_BITS'(LAG);
                    n_state  = ST_SETUP;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SETUP: begin
                n_state = ST_MAC;
            end
            ST_MAC: begin
                if (i_stat.mac_done) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    if (r_last && !w_final) begin
                        n_center = r_center + IDX_BITS'(1);
                        n_state  = ST_SETUP;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.center = r_center;
        o_cmd.last   = w_final;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.shift = i_in_valid;
            end
            ST_SETUP: begin
                o_cmd.start = 1'b1;
            end
            ST_MAC: begin
                o_cmd.mac_en    = 1'b1;
                o_cmd.div_start = i_stat.mac_done;
            end
            ST_DIV: begin
                o_cmd.div_step = !i_stat.div_done;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
            end
            ST_OUT: begin
                o_cmd.load_out   = i_stat.out_free;
                o_cmd.clear_seen = i_stat.out_free && w_final;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_center <= '0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_center <= n_center;
            r_last   <= n_last;
        end
    end

endmodule

FILE: rtl/core/path_point_smoothing_filter_unit.sv
// Top level of the path point smoothing filter: controller, datapath and checks.
//
// Input beats carry one path point (i_in_x, i_in_y, signed fixed point) and
// i_in_last, which closes a sequence. Output beats carry smoothed points in
// the same format, with o_out_last set on the final point of each sequence.
// Both channels use valid/ready; a beat moves when valid and ready are high.
// The mode register (i_cfg_we, i_cfg_data) selects pass-through, three-point
// averaging or seven-tap weighted smoothing. It must be written only while
// idle; the block itself does not enforce this. A point is emitted once
// three newer points have arrived; the last beat of a sequence flushes
// every pending point, so one input beat yields zero to four output beats.
// Each result takes one to seven taps of multiply-accumulate and a drain
// of the product register, then a 40-step divider that yields one quotient
// bit per cycle, then a rounding step.
// The input is taken only while the controller is idle; a finished result
// sits in the output register, so the next point can be taken while it waits.
// If the receiver stalls, the next result is held in the datapath until the
// output register frees. Reset is synchronous and active low: it clears the
// point count, the mode (pass-through) and both valid flags.
module path_point_smoothing_filter_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [ppsf_pkg::MODE_BITS-1:0]          i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic signed [ppsf_pkg::COORD_BITS-1:0]  i_in_x,
    input  logic signed [ppsf_pkg::COORD_BITS-1:0]  i_in_y,
    input  logic                                    i_in_last,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [ppsf_pkg::COORD_BITS-1:0]  o_out_x,
    output logic signed [ppsf_pkg::COORD_BITS-1:0]  o_out_y,
    output logic                                    o_out_last
);
    import ppsf_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // The controller owns sequencing; it sees the datapath only through status.
    ppsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_last),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the point window, the arithmetic and the output beat.
    ppsf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_x      (i_in_x),
        .i_in_y      (i_in_y),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_last  (o_out_last)
    );

`ifndef ASSERT_OFF
    // The divider must only be loaded once accumulation has drained and it is free.
    a_div_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> (w_stat.mac_done && w_stat.div_done))
        else $error("divider loaded while busy or before accumulation finished");

    // Rounding must see a finished quotient.
    a_round_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.round |-> w_stat.div_done)
        else $error("rounding started before division finished");

    // After the final point of a sequence leaves, the next sequence starts empty.
    a_seq_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.load_out && w_cmd.last) |=> (w_stat.seen == '0))
        else $error("point count not cleared at end of sequence");
`endif

endmodule

FILE: tb/sv/ppsf_smooth_checker.sv
// Checker for the path point smoothing filter: predicts smoothed points and compares beats.
module ppsf_smooth_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [ppsf_pkg::MODE_BITS-1:0]          i_cfg_data,
    input  logic                                    i_in_valid,
    input  logic                                    i_in_ready,
    input  logic signed [ppsf_pkg::COORD_BITS-1:0]  i_in_x,
    input  logic signed [ppsf_pkg::COORD_BITS-1:0]  i_in_y,
    input  logic                                    i_in_last,
    input  logic                                    i_out_valid,
    input  logic                                    i_out_ready,
    input  logic signed [ppsf_pkg::COORD_BITS-1:0]  i_out_x,
    input  logic signed [ppsf_pkg::COORD_BITS-1:0]  i_out_y,
    input  logic                                    i_out_last,
    output int                                      o_pending,
    output int                                      o_fail_count
);
    import ppsf_pkg::*;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         last;
    } smoothed_point_t;

    logic signed [COORD_BITS-1:0] x_win [WIN_LEN];
    logic signed [COORD_BITS-1:0] y_win [WIN_LEN];
    int                           points_held;
    logic [MODE_BITS-1:0]         cur_mode;
    smoothed_point_t              smoothed_q [$];
    int                           mismatches;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        mismatches   = 0;
        points_held  = 0;
        cur_mode     = MODE_PASS;
    end

    function automatic longint tap_weight(input int k);
        case (k)
            0, 6:    return 2;
            1, 5:    return 16;
            2, 4:    return 38;
            default: return 49;
        endcase
    endfunction

    // Rounds to nearest, with ties pushed away from zero.
    function automatic logic signed [COORD_BITS-1:0] div_round(input longint acc,
                                                               input longint den);
        longint mag;
        longint q;
        longint r;
        mag = (acc < 0) ? -acc : acc;
        q   = mag / den;
        r   = mag % den;
        if (r >= den - r)
            q++;
        if (acc < 0)
            q = -q;
        return q[COORD_BITS-1:0];
    endfunction

    function automatic smoothed_point_t smooth_at(input int c, input int n_old,
                                                  input int n_new, input logic last);
        smoothed_point_t r;
        longint          sx;
        longint          sy;
        longint          den;
        int              k;
        if (n_old > LAG) n_old = LAG;
        if (n_new > LAG) n_new = LAG;
        r.last = last;
        if (cur_mode == MODE_WTD) begin
            sx  = 0;
            sy  = 0;
            den = 0;
            for (k = -n_old; k <= n_new; k++) begin
                sx  += longint'(x_win[c + k]) * tap_weight(k + LAG);
                sy  += longint'(y_win[c + k]) * tap_weight(k + LAG);
                den += tap_weight(k + LAG);
            end
            r.x = div_round(sx, den);
            r.y = div_round(sy, den);
        end else if (cur_mode == MODE_AVG3 && n_old >= 1 && n_new >= 1
                     && c >= 1 && c + 1 < WIN_LEN) begin
            sx  = longint'(x_win[c-1]) + longint'(x_win[c]) + longint'(x_win[c+1]);
            sy  = longint'(y_win[c-1]) + longint'(y_win[c]) + longint'(y_win[c+1]);
            r.x = div_round(sx, 3);
            r.y = div_round(sy, 3);
        end else begin
            r.x = x_win[c];
            r.y = y_win[c];
        end
        return r;
    endfunction

    // Shifts the new point into the window and queues the points it releases.
    task automatic take_point(input logic signed [COORD_BITS-1:0] px,
                              input logic signed [COORD_BITS-1:0] py,
                              input logic pl);
        int i;
        int c;
        int flushed;
        int first;
        for (i = 0; i < WIN_LEN - 1; i++) begin
            x_win[i] = x_win[i+1];
            y_win[i] = y_win[i+1];
        end
        x_win[WIN_LEN-1] = px;
        y_win[WIN_LEN-1] = py;
        if (points_held < WIN_LEN)
            points_held++;
        if (!pl) begin
            if (points_held > LAG)
                smoothed_q.push_back(smooth_at(LAG, points_held - LAG - 1, LAG, 1'b0));
        end else begin
            flushed = (points_held > LAG) ? LAG + 1 : points_held;
            first   = WIN_LEN - points_held;
            for (c = WIN_LEN - flushed; c < WIN_LEN; c++)
                smoothed_q.push_back(smooth_at(c, c - first, WIN_LEN - 1 - c,
                                               c == WIN_LEN - 1));
            points_held = 0;
        end
    endtask

    task automatic check_result();
        smoothed_point_t want;
        if (smoothed_q.size() == 0) begin
            $error("unexpected result beat: x=%0d y=%0d last=%0b",
                   i_out_x, i_out_y, i_out_last);
            mismatches++;
        end else begin
            want = smoothed_q.pop_front();
            if (i_out_x !== want.x) begin
                $error("o_out_x: expected %0d, got %0d", want.x, i_out_x);
                mismatches++;
            end
            if (i_out_y !== want.y) begin
                $error("o_out_y: expected %0d, got %0d", want.y, i_out_y);
                mismatches++;
            end
            if (i_out_last !== want.last) begin
                $error("o_out_last: expected %0b, got %0b", want.last, i_out_last);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_LEN; i++) begin
                x_win[i] = '0;
                y_win[i] = '0;
            end
            points_held = 0;
            cur_mode    = MODE_PASS;
            smoothed_q.delete();
        end else begin
            if (i_cfg_we)
                cur_mode = i_cfg_data;
            // A result beat can never stem from an input beat of the same edge.
            if (i_out_valid && i_out_ready)
                check_result();
            if (i_in_valid && i_in_ready)
                take_point(i_in_x, i_in_y, i_in_last);
        end
        o_pending    <= smoothed_q.size();
        o_fail_count <= mismatches;
    end

endmodule

FILE: tb/sv/tb_path_point_smoothing_filter_unit.sv
// Testbench top for the path point smoothing filter: stimulus, back-pressure and verdict.
module tb_path_point_smoothing_filter_unit;
    import ppsf_pkg::*;

    // Mode code that the block does not define; it must behave as pass-through.
    localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = 32'sh8000_0000;

    // The quiet spell of SETTLE_CYCLES covers a point still being worked on
    // after the last expected beat has left.
    localparam int SETTLE_CYCLES   = 80;
    localparam int LONG_HOLD       = 400;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 55;
    localparam int CYCLE_LIMIT     = 600000;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [MODE_BITS-1:0]          i_cfg_data  = MODE_PASS;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    logic signed [COORD_BITS-1:0]  i_in_x      = '0;
    logic signed [COORD_BITS-1:0]  i_in_y      = '0;
    logic                          i_in_last   = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic signed [COORD_BITS-1:0]  o_out_x;
    logic signed [COORD_BITS-1:0]  o_out_y;
    logic                          o_out_last;

    int points_pending;
    int fail_count;

    // Requests for a long receiver hold-off; the receiver serves each one.
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int stall_style   = 0;
    int style_left    = 0;
    int burst_left    = 0;
    int cycle_count   = 0;

    logic signed [COORD_BITS-1:0] prev_x = '0;
    logic signed [COORD_BITS-1:0] prev_y = '0;

    path_point_smoothing_filter_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_x      (i_in_x),
        .i_in_y      (i_in_y),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_last  (o_out_last)
    );

    ppsf_smooth_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_x       (i_in_x),
        .i_in_y       (i_in_y),
        .i_in_last    (i_in_last),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_x      (o_out_x),
        .i_out_y      (o_out_y),
        .i_out_last   (o_out_last),
        .o_pending    (points_pending),
        .o_fail_count (fail_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver. It switches between always ready, ready about half the time
    // and ready about one cycle in four, each for a random stretch. When a
    // long hold-off is requested it drops ready for a LONG_HOLD span, counted
    // here, while the sender keeps offering beats, so the output register and
    // the datapath both fill and the block has to refuse input.
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (style_left == 0) begin
                stall_style = $urandom_range(0, 2);
                style_left  = $urandom_range(20, 300);
            end
            style_left--;
            case (stall_style)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= ($urandom_range(0, 1) != 0);
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Coordinates: half are fully random words so that every bit toggles, some
    // small steps from the previous point as a real path would give, and
    // some extremes and values close to zero.
    function automatic logic signed [COORD_BITS-1:0] pick_coord(
            input logic signed [COORD_BITS-1:0] prev);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom;
            5, 6, 7:       return prev + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            8: begin
                case ($urandom_range(0, 4))
                    0:       return COORD_MAX;
                    1:       return COORD_MIN;
                    2:       return '0;
                    3:       return -1;
                    default: return 1;
                endcase
            end
            default:       return $signed($urandom_range(0, 6)) - 3;
        endcase
    endfunction

    function automatic logic [MODE_BITS-1:0] phase_mode(input int ph);
        case (ph)
            0, 6:    return MODE_PASS;
            1, 5:    return MODE_AVG3;
            3:       return MODE_SPARE;
            default: return MODE_WTD;
        endcase
    endfunction

    // Offers one point and returns at the edge that accepts it, with valid
    // still high. The sender works in bursts; between bursts valid drops for
    // a random gap, sometimes a long one, sometimes none at all.
    task automatic push_point(input logic signed [COORD_BITS-1:0] px,
                              input logic signed [COORD_BITS-1:0] py,
                              input logic pl);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(13, 70);
                default: gap = $urandom_range(1, 12);
            endcase
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_x     <= px;
        i_in_y     <= py;
        i_in_last  <= pl;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Sender pause: valid low until every expected beat has come back, then
    // a quiet spell in case a point without a result is still in work.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (points_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [MODE_BITS-1:0] m);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        int   seq_left;
        logic is_last;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, weighted mode first: a single point, a pair, a
        // triple near zero and a sequence longer than the window, the rest at
        // extremes, so the dropped taps at both ends and the saturated window show up.
        write_mode(MODE_WTD);
        push_point(COORD_MAX, COORD_MIN, 1'b1);
        push_point(COORD_MIN, COORD_MAX, 1'b0);
        push_point(COORD_MAX, COORD_MIN, 1'b1);
        push_point(-1, 1, 1'b0);
        push_point(0, 0, 1'b0);
        push_point(1, -1, 1'b1);
        for (int i = 0; i < 8; i++)
            push_point((i % 2 == 0) ? COORD_MAX : COORD_MIN,
                       (i % 2 == 0) ? COORD_MIN : COORD_MAX, i == 7);

        // Three-point averaging, then a switch to the undefined mode code in
        // the middle of the sequence, while the block is idle: the held points
        // are emitted with the mode that is in force when they leave.
        drain_results();
        write_mode(MODE_AVG3);
        push_point(COORD_MAX, COORD_MAX, 1'b0);
        push_point(COORD_MIN, COORD_MIN, 1'b0);
        drain_results();
        write_mode(MODE_SPARE);
        push_point(COORD_MAX, -1, 1'b0);
        push_point(0, COORD_MIN, 1'b0);
        push_point(1, COORD_MAX, 1'b1);

        // Random part: one mode setting per phase. A sequence may run across
        // a phase boundary, which again changes the mode under held points.
        seq_left = 0;
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            write_mode(phase_mode(ph));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (seq_left == 0)
                    seq_left = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                           : $urandom_range(1, 12);
                is_last = (seq_left == 1) || (ph == PHASES - 1 && n == ITEMS_PER_PHASE - 1);
                seq_left = is_last ? 0 : seq_left - 1;
                px = pick_coord(prev_x);
                py = pick_coord(prev_y);
                prev_x = px;
                prev_y = py;
                if ((ph == 2 || ph == 5) && n == 5)
                    hold_requests <= hold_requests + 1;
                if (ph == 4 && n == 30)
                    drain_results();
                push_point(px, py, is_last);
            end
        end

        drain_results();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: path_point_smoothing_filter_unit.f
rtl/core/ppsf_pkg.sv
rtl/core/ppsf_datapath.sv
rtl/core/ppsf_ctrl.sv
rtl/core/path_point_smoothing_filter_unit.sv
tb/sv/ppsf_smooth_checker.sv
tb/sv/tb_path_point_smoothing_filter_unit.sv
